// File: rtl/loglog_spread_prefilter_defines.svh
// ----------------------------------------------------------------------------
// loglog spread prefilter assertion macros
// shared property shorthands for the checker
// ----------------------------------------------------------------------------
`ifndef LOGLOG_SPREAD_PREFILTER_DEFINES_SVH
`define LOGLOG_SPREAD_PREFILTER_DEFINES_SVH

// same-cycle implication
`define LSP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: lsp check failed");

// next-cycle implication
`define LSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: lsp check failed");

`endif

// File: rtl/lsp_pkg.sv
// ----------------------------------------------------------------------------
// lsp_pkg
// sizes, hash constants and shared types of the loglog spread prefilter
// ----------------------------------------------------------------------------
package lsp_pkg;

   // level memory depth, a power of two
   localparam int NUM_REGS   = 4096;
   localparam int HASHES     = 3;

   localparam int IDX_W      = $clog2(NUM_REGS);
   localparam int SLOT_W     = (HASHES > 1) ? $clog2(HASHES) : 1;
   localparam int ISSUE_W    = $clog2(2 * HASHES);
   localparam int LEVEL_W    = 4;
   localparam int SEED_W     = 31;
   localparam int WORD_W     = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [LEVEL_W-1:0] CAP_NORMAL   = 4'd5;
   localparam logic [LEVEL_W-1:0] CAP_PER_FLOW = 4'd10;

   // murmur3 x86_32 constants, one 4-byte block
   localparam logic [WORD_W-1:0] MUR_C1  = 32'hcc9e2d51;
   localparam logic [WORD_W-1:0] MUR_C2  = 32'h1b873593;
   localparam logic [WORD_W-1:0] MUR_N   = 32'he6546b64;
   localparam logic [WORD_W-1:0] MUR_LEN = 32'd4;
   localparam logic [WORD_W-1:0] MUR_F1  = 32'h85ebca6b;
   localparam logic [WORD_W-1:0] MUR_F2  = 32'hc2b2ae35;

   typedef enum logic [1:0] {
      REG_MODE,
      REG_SEED_ZERO,
      REG_SEED_ONE,
      REG_SEED_TWO
   } csr_reg_type;

   // what travels with a word through the hash pipeline
   typedef struct packed {
      logic              is_elem;
      logic [SLOT_W-1:0] slot;
   } hash_tag_type;

endpackage

// File: rtl/lsp_hash.sv
// ----------------------------------------------------------------------------
// lsp_hash
// six-stage murmur3 x86_32 pipeline over one 32-bit word, one word a cycle
// ----------------------------------------------------------------------------
module lsp_hash (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  lsp_pkg::hash_tag_type        in_tag,
   input  logic [lsp_pkg::WORD_W-1:0]   in_word,
   input  logic [lsp_pkg::SEED_W-1:0]   in_seed,
   output logic                         out_valid,
   output lsp_pkg::hash_tag_type        out_tag,
   output logic [lsp_pkg::WORD_W-1:0]   out_hash
);
   import lsp_pkg::*;

   localparam int LAT = 6;

   logic [LAT-1:0]    vld_ff;
   hash_tag_type      tag_ff [LAT];

   logic [WORD_W-1:0] s1_k_ff;
   logic [SEED_W-1:0] s1_seed_ff;
   logic [WORD_W-1:0] s2_k_ff;
   logic [SEED_W-1:0] s2_seed_ff;
   logic [WORD_W-1:0] s3_a_ff;
   logic [WORD_W-1:0] s4_b_ff;
   logic [WORD_W-1:0] s5_d_ff;
   logic [WORD_W-1:0] s6_h_ff;

   logic [WORD_W-1:0] s2_rot;
   logic [WORD_W-1:0] s3_a_in;
   logic [WORD_W-1:0] s5_c;
   logic [WORD_W-1:0] s6_h_in;

   always_comb begin
      logic [WORD_W-1:0] h0;
      logic [WORD_W-1:0] h1;
      logic [WORD_W-1:0] h2;
      logic [WORD_W-1:0] h3;
      s2_rot  = {s1_k_ff[16:0], s1_k_ff[31:17]};
      h0      = {1'b0, s2_seed_ff} ^ s2_k_ff;
      h1      = {h0[18:0], h0[31:19]};
      h2      = (h1 << 2) + h1 + MUR_N;
      h3      = h2 ^ MUR_LEN;
      s3_a_in = h3 ^ (h3 >> 16);
      s5_c    = s4_b_ff ^ (s4_b_ff >> 13);
      s6_h_in = s5_d_ff ^ (s5_d_ff >> 16);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      tag_ff[0] <= in_tag;
      for (int i = 1; i < LAT; i++) begin
         tag_ff[i] <= tag_ff[i-1];
      end
      s1_k_ff    <= in_word * MUR_C1;
      s1_seed_ff <= in_seed;
      s2_k_ff    <= s2_rot * MUR_C2;
      s2_seed_ff <= s1_seed_ff;
      s3_a_ff    <= s3_a_in;
      s4_b_ff    <= s3_a_ff * MUR_F1;
      s5_d_ff    <= s5_c * MUR_F2;
      s6_h_ff    <= s6_h_in;
   end

   assign out_valid = vld_ff[LAT-1];
   assign out_tag   = tag_ff[LAT-1];
   assign out_hash  = s6_h_ff;

endmodule

// File: rtl/loglog_spread_prefilter.sv
// ----------------------------------------------------------------------------
// loglog_spread_prefilter
// multi-hash loglog prefilter in front of a spread sketch. Each request beat
// carries a flow key and an element. The key is hashed under the three seeds
// to pick three 4-bit level registers in a 4096-entry memory; their minimum
// is compared with the cap (5, or 10 in per-flow mode). Below the cap, each
// picked register is raised to the capped leading-zero count of the
// element's hash under the same seed and the beat is not passed on; at or
// above the cap the registers stay and passed_on is set. Every request gives
// exactly one response beat carrying passed_on and the minimum seen before
// the update. Items are handled one at a time: a request beat is taken only
// after the previous one has gone through the issue, hash, read, drain,
// decide, write (only when the registers are updated) and out states, run
// on the shared six-stage hash pipeline taking one word a cycle and the
// level memory doing one read or one write a cycle. A finished response
// waits in an output register, so the next request is taken while it
// stalls. After reset the level memory is cleared one entry a cycle with
// req_stall high; csr writes are taken during the sweep. The memory depth
// must be a power of two. Registers sit at byte addresses 0 (per_flow_mode),
// 4, 8 and 12 (seeds).
// ----------------------------------------------------------------------------
module loglog_spread_prefilter (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [31:0]                      req_flow_key,
   input  logic [31:0]                      req_element_value,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_passed_on,
   output logic [3:0]                       rsp_min_level,
   // register port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [lsp_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [lsp_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [lsp_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import lsp_pkg::*;

   localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(HASHES - 1);
   localparam logic [ISSUE_W-1:0] LAST_ISSUE = ISSUE_W'(2 * HASHES - 1);
   localparam logic [ISSUE_W-1:0] ELEM_FIRST = ISSUE_W'(HASHES);
   localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(NUM_REGS - 1);
   localparam int                 LZ_SPAN    = 10;

   typedef enum logic [3:0] {
      ST_CLEAR,   // sweep zeros through the level memory
      ST_IDLE,    // ready for a request beat
      ST_ISSUE,   // feed key and element words into the hash pipeline
      ST_HASH,    // wait for the last element hash
      ST_READ,    // one level read per cycle
      ST_DRAIN,   // last read data lands
      ST_DECIDE,  // minimum, cap compare, new levels
      ST_WRITE,   // one level write per cycle
      ST_OUT      // hand the result to the response register
   } state_type;

   state_type state_ff;
   state_type state_in;

   // configuration
   logic                 mode_ff;
   logic [SEED_W-1:0]    seed_zero_ff;
   logic [SEED_W-1:0]    seed_one_ff;
   logic [SEED_W-1:0]    seed_two_ff;
   logic                 csr_wr;
   csr_reg_type          csr_reg;
   logic [LEVEL_W-1:0]   cap;

   // sequencing
   logic [IDX_W-1:0]     clr_cnt_ff;
   logic [ISSUE_W-1:0]   issue_cnt_ff;
   logic [SLOT_W-1:0]    rd_cnt_ff;
   logic [SLOT_W-1:0]    wr_cnt_ff;
   logic                 rd_pend_ff;
   logic [SLOT_W-1:0]    rd_slot_ff;

   // per-item working set
   logic [31:0]          key_ff;
   logic [31:0]          elem_ff;
   logic [IDX_W-1:0]     idx_ff   [HASHES];
   logic [LEVEL_W-1:0]   lz_ff    [HASHES];
   logic [LEVEL_W-1:0]   level_ff [HASHES];
   logic [LEVEL_W-1:0]   new_ff   [HASHES];
   logic                 res_passed_ff;
   logic [LEVEL_W-1:0]   res_min_ff;

   // response register
   logic                 rsp_valid_ff;
   logic                 rsp_passed_ff;
   logic [LEVEL_W-1:0]   rsp_min_ff;

   // hash pipeline hookup
   logic                 hash_in_valid;
   hash_tag_type         hash_in_tag;
   logic [31:0]          hash_in_word;
   logic [SEED_W-1:0]    hash_in_seed;
   logic                 hash_out_valid;
   hash_tag_type         hash_out_tag;
   logic [31:0]          hash_out;
   logic [LEVEL_W-1:0]   hash_lz;

   // level memory
   logic [LEVEL_W-1:0]   level_mem [NUM_REGS];
   logic [LEVEL_W-1:0]   rd_data_ff;
   logic [IDX_W-1:0]     mem_raddr;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   logic [LEVEL_W-1:0]   mem_wdata;

   // decision
   logic [LEVEL_W-1:0]   gamma;
   logic                 under_cap;
   logic [LEVEL_W-1:0]   new_level [HASHES];

   logic                 req_take;
   logic                 rsp_free;

   // ---------------------------------------------------------------- csr port
   assign pready  = 1'b1;
   assign csr_reg = csr_reg_type'(paddr[CSR_ADDR_W-1:2]);
   assign csr_wr  = psel && penable && pwrite;

   always_comb begin
      unique case (csr_reg)
         REG_MODE:      prdata = {{(CSR_DATA_W-1){1'b0}}, mode_ff};
         REG_SEED_ZERO: prdata = {1'b0, seed_zero_ff};
         REG_SEED_ONE:  prdata = {1'b0, seed_one_ff};
         REG_SEED_TWO:  prdata = {1'b0, seed_two_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         seed_zero_ff <= '0;
         seed_one_ff  <= '0;
         seed_two_ff  <= '0;
      end else if (csr_wr) begin
         unique case (csr_reg)
            REG_MODE:      mode_ff      <= pwdata[0];
            REG_SEED_ZERO: seed_zero_ff <= pwdata[SEED_W-1:0];
            REG_SEED_ONE:  seed_one_ff  <= pwdata[SEED_W-1:0];
            REG_SEED_TWO:  seed_two_ff  <= pwdata[SEED_W-1:0];
         endcase
      end
   end

   assign cap = mode_ff ? CAP_PER_FLOW : CAP_NORMAL;

   // ------------------------------------------------------------ handshakes
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_passed_on = rsp_passed_ff;
   assign rsp_min_level = rsp_min_ff;

   // ---------------------------------------------------------- hash issue
   // key words first, then element words, seed order within each
   always_comb begin
      hash_in_valid       = (state_ff == ST_ISSUE);
      hash_in_tag.is_elem = (issue_cnt_ff >= ELEM_FIRST);
      hash_in_tag.slot    = hash_in_tag.is_elem ? SLOT_W'(issue_cnt_ff - ELEM_FIRST)
                                                : SLOT_W'(issue_cnt_ff);
      hash_in_word        = hash_in_tag.is_elem ? elem_ff : key_ff;
      priority if (hash_in_tag.slot == SLOT_W'(0)) begin
         hash_in_seed = seed_zero_ff;
      end else if (hash_in_tag.slot == SLOT_W'(1)) begin
         hash_in_seed = seed_one_ff;
      end else begin
         hash_in_seed = seed_two_ff;
      end
   end

   lsp_hash u_hash (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (hash_in_valid),
      .in_tag    (hash_in_tag),
      .in_word   (hash_in_word),
      .in_seed   (hash_in_seed),
      .out_valid (hash_out_valid),
      .out_tag   (hash_out_tag),
      .out_hash  (hash_out)
   );

   // leading zeros of the element hash, limited to the cap; only the top
   // bits up to the largest cap matter
   always_comb begin
      logic [LEVEL_W-1:0] n;
      n = LEVEL_W'(LZ_SPAN);
      for (int i = LZ_SPAN - 1; i >= 0; i--) begin
         if (hash_out[31-i]) begin
            n = LEVEL_W'(i);
         end
      end
      hash_lz = (n > cap) ? cap : n;
   end

   // ---------------------------------------------------------- level memory
   always_comb begin
      mem_raddr = idx_ff[rd_cnt_ff];
      mem_we    = (state_ff == ST_CLEAR) || (state_ff == ST_WRITE);
      if (state_ff == ST_CLEAR) begin
         mem_waddr = clr_cnt_ff;
         mem_wdata = '0;
      end else begin
         mem_waddr = idx_ff[wr_cnt_ff];
         mem_wdata = new_ff[wr_cnt_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         level_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= level_mem[mem_raddr];
   end

   // ---------------------------------------------------------- decision
   // repeated indices: every slot on the same entry gets the largest level
   // among them, so the sequential writes agree
   always_comb begin
      gamma = '1;
      for (int i = 0; i < HASHES; i++) begin
         if (level_ff[i] < gamma) begin
            gamma = level_ff[i];
         end
      end
      for (int i = 0; i < HASHES; i++) begin
         new_level[i] = level_ff[i];
         for (int j = 0; j < HASHES; j++) begin
            if ((idx_ff[j] == idx_ff[i]) && (lz_ff[j] > new_level[i])) begin
               new_level[i] = lz_ff[j];
            end
         end
      end
      under_cap = (gamma < cap);
   end

   // ---------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clr_cnt_ff == LAST_IDX) state_in = ST_IDLE;
         ST_IDLE:   if (req_take) state_in = ST_ISSUE;
         ST_ISSUE:  if (issue_cnt_ff == LAST_ISSUE) state_in = ST_HASH;
         ST_HASH: begin
            if (hash_out_valid && hash_out_tag.is_elem && (hash_out_tag.slot == LAST_SLOT)) begin
               state_in = ST_READ;
            end
         end
         ST_READ:   if (rd_cnt_ff == LAST_SLOT) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = ST_DECIDE;
         ST_DECIDE: state_in = under_cap ? ST_WRITE : ST_OUT;
         ST_WRITE:  if (wr_cnt_ff == LAST_SLOT) state_in = ST_OUT;
         ST_OUT:    if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // state, counters and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         issue_cnt_ff <= '0;
         rd_cnt_ff    <= '0;
         wr_cnt_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= (state_ff == ST_READ);
         if (state_ff == ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         issue_cnt_ff <= (state_ff == ST_ISSUE) ? issue_cnt_ff + 1'b1 : '0;
         rd_cnt_ff    <= (state_ff == ST_READ)  ? rd_cnt_ff + 1'b1    : '0;
         wr_cnt_ff    <= (state_ff == ST_WRITE) ? wr_cnt_ff + 1'b1    : '0;
         if (state_ff == ST_OUT && rsp_free) begin
            rsp_valid_ff  <= 1'b1;
            rsp_passed_ff <= res_passed_ff;
            rsp_min_ff    <= res_min_ff;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working set, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         key_ff  <= req_flow_key;
         elem_ff <= req_element_value;
      end
      if (hash_out_valid) begin
         if (hash_out_tag.is_elem) begin
            lz_ff[hash_out_tag.slot] <= hash_lz;
         end else begin
            idx_ff[hash_out_tag.slot] <= hash_out[IDX_W-1:0];
         end
      end
      rd_slot_ff <= rd_cnt_ff;
      if (rd_pend_ff) begin
         level_ff[rd_slot_ff] <= rd_data_ff;
      end
      if (state_ff == ST_DECIDE) begin
         res_passed_ff <= !under_cap;
         res_min_ff    <= gamma;
         for (int i = 0; i < HASHES; i++) begin
            new_ff[i] <= new_level[i];
         end
      end
   end

endmodule

// File: rtl/lsp_checker.sv
// ----------------------------------------------------------------------------
// lsp_checker
// port-level checks of the loglog spread prefilter, bound to the top level
// ----------------------------------------------------------------------------
`include "loglog_spread_prefilter_defines.svh"

module lsp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_passed_on,
   input logic [3:0] rsp_min_level
);

   // one item at a time: a taken request closes the door
   `LSP_ASSERT_NEXT(a_one_in_flight, clock, reset, (req_valid && !req_stall), (req_stall))

   // a pair passed on saw at least the smaller cap
   `LSP_ASSERT_IMPLY(a_passed_level, clock, reset, (rsp_valid && rsp_passed_on), (rsp_min_level >= 4'd5))

   // a filtered pair saw less than the larger cap
   `LSP_ASSERT_IMPLY(a_kept_level, clock, reset, (rsp_valid && !rsp_passed_on), (rsp_min_level <= 4'd9))

   // stalled response beat holds
   `LSP_ASSERT_NEXT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall), (rsp_valid && $stable(rsp_passed_on) && $stable(rsp_min_level)))

endmodule

bind loglog_spread_prefilter lsp_checker u_lsp_checker (.*);
